// ===== design/wja_pkg.sv =====
// ----------------------------------------------------------------------------
// wja_pkg
// shared constants and controller/datapath command and status types for the
// weighted jaccard accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package wja_pkg;

    localparam int VALUE_BITS_DEF    = 32;
    localparam int SUM_BITS_DEF      = 48;
    localparam int FRACTION_BITS_DEF = 16;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic load_div;
        logic div_step;
        logic div_first;
        logic out_load;
    } wja_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic out_full;
    } wja_status_t;

endpackage

`default_nettype wire

// ===== design/wja_if.sv =====
// ----------------------------------------------------------------------------
// wja_if
// valid/ready channels for element pairs and similarity results
// ----------------------------------------------------------------------------
`default_nettype none

interface wja_pair_if #(
    parameter int VALUE_W = 32
);
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_a;
    logic               null_a;
    logic [VALUE_W-1:0] value_b;
    logic               null_b;
    logic               last_element;

    modport source (output valid, value_a, null_a, value_b, null_b, last_element,
                    input ready);
    modport sink   (input valid, value_a, null_a, value_b, null_b, last_element,
                    output ready);
endinterface

interface wja_result_if #(
    parameter int SUM_W = 48,
    parameter int SIM_W = 17
);
    logic             valid;
    logic             ready;
    logic [SIM_W-1:0] similarity;
    logic [SUM_W-1:0] sum_of_minima;
    logic [SUM_W-1:0] sum_of_maxima;
    logic             empty_flag;
    logic             overflow_flag;

    modport source (output valid, similarity, sum_of_minima, sum_of_maxima,
                    empty_flag, overflow_flag, input ready);
    modport sink   (input valid, similarity, sum_of_minima, sum_of_maxima,
                    empty_flag, overflow_flag, output ready);
endinterface

`default_nettype wire

// ===== design/weighted_jaccard_accumulator.sv =====
// ----------------------------------------------------------------------------
// weighted_jaccard_accumulator
// Takes one pair of vector elements per item and accumulates the smaller and
// larger values into saturating sums, skipping pairs with a null side. Items
// are taken one per cycle while no divide is running. On the item marked last
// the block divides the min sum by the max sum with a restoring divider that
// produces one quotient bit per cycle, so ready stays low after that item
// through the FRACTION_BITS + 1 divide steps and the load of the result
// register, longer only if the previous result has not yet been taken. A
// pending result does not hold back items that are not last. An empty vector
// gives similarity 0 with empty_flag set.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_jaccard_accumulator #(
    parameter int VALUE_BITS    = wja_pkg::VALUE_BITS_DEF,
    parameter int SUM_BITS      = wja_pkg::SUM_BITS_DEF,
    parameter int FRACTION_BITS = wja_pkg::FRACTION_BITS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    wja_pair_if.sink     pairs,
    wja_result_if.source results
);
    import wja_pkg::*;

    wja_cmd_t    cmd;
    wja_status_t status;

    wja_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    wja_datapath #(
        .VALUE_BITS    (VALUE_BITS),
        .SUM_BITS      (SUM_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .pairs   (pairs),
        .results (results),
        .cmd     (cmd),
        .status  (status)
    );

`ifndef SYNTHESIS
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_div |=> !pairs.ready)
        else $error("item taken while dividing");

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.similarity <= (FRACTION_BITS + 1)'(1) << FRACTION_BITS)
        else $error("similarity above one");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.empty_flag |-> results.similarity == '0)
        else $error("empty result with nonzero similarity");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.sum_of_minima <= results.sum_of_maxima)
        else $error("min sum above max sum");
`endif

endmodule

`default_nettype wire

// ===== design/wja_ctrl.sv =====
// ----------------------------------------------------------------------------
// wja_ctrl
// sequencer: accumulate items, run the restoring divider, hand off the result
// ----------------------------------------------------------------------------
`default_nettype none

module wja_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wja_pkg::wja_status_t status,
    output wja_pkg::wja_cmd_t    cmd
);
    import wja_pkg::*;

    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_ACC:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_last)
                    begin
                        cmd.load_div = 1'b1;
                        cnt_next     = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(FRACTION_BITS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/wja_datapath.sv =====
// ----------------------------------------------------------------------------
// wja_datapath
// saturating min/max accumulators, bit-serial fraction divider, result register
// ----------------------------------------------------------------------------
`default_nettype none

module wja_datapath #(
    parameter int VALUE_BITS    = 32,
    parameter int SUM_BITS      = 48,
    parameter int FRACTION_BITS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    wja_pair_if.sink              pairs,
    wja_result_if.source          results,
    input  wja_pkg::wja_cmd_t     cmd,
    output wja_pkg::wja_status_t  status
);
    import wja_pkg::*;

    localparam int SIM_BITS = FRACTION_BITS + 1;

    logic [SUM_BITS-1:0] min_acc_reg, min_acc_next;
    logic [SUM_BITS-1:0] max_acc_reg, max_acc_next;
    logic                sat_reg, sat_next;

    logic [SUM_BITS-1:0] min_snap_reg, max_snap_reg;
    logic                ovf_snap_reg;
    logic [SUM_BITS:0]   rem_reg, rem_next;
    logic [SIM_BITS-1:0] quo_reg, quo_next;

    logic [SIM_BITS-1:0] sim_reg;
    logic [SUM_BITS-1:0] sum_min_reg, sum_max_reg;
    logic                empty_reg, ovf_reg;
    logic                out_valid_reg;

    logic [VALUE_BITS-1:0] lo, hi;
    logic                  skip;
    logic [SUM_BITS:0]     min_wide, max_wide;
    logic [SUM_BITS-1:0]   min_sum, max_sum;
    logic                  min_ovf, max_ovf;
    logic [SUM_BITS:0]     shifted, den_wide;
    logic                  ge;

    assign pairs.ready     = cmd.in_ready;
    assign status.in_valid = pairs.valid;
    assign status.in_last  = pairs.last_element;
    assign status.out_full = out_valid_reg && !results.ready;

    // min/max of the pair and saturating sums
    always_comb
    begin
        skip     = pairs.null_a || pairs.null_b;
        lo       = (pairs.value_a < pairs.value_b) ? pairs.value_a : pairs.value_b;
        hi       = (pairs.value_a < pairs.value_b) ? pairs.value_b : pairs.value_a;
        min_wide = {1'b0, min_acc_reg} + (SUM_BITS + 1)'(lo);
        max_wide = {1'b0, max_acc_reg} + (SUM_BITS + 1)'(hi);
        min_ovf  = min_wide[SUM_BITS];
        max_ovf  = max_wide[SUM_BITS];
        min_sum  = min_acc_reg;
        max_sum  = max_acc_reg;
        sat_next = sat_reg;
        if (!skip)
        begin
            min_sum  = min_ovf ? '1 : min_wide[SUM_BITS-1:0];
            max_sum  = max_ovf ? '1 : max_wide[SUM_BITS-1:0];
            sat_next = sat_reg || min_ovf || max_ovf;
        end
        min_acc_next = min_acc_reg;
        max_acc_next = max_acc_reg;
        if (cmd.accept)
        begin
            min_acc_next = cmd.load_div ? '0 : min_sum;
            max_acc_next = cmd.load_div ? '0 : max_sum;
        end
    end

    // one restoring division step per cycle
    always_comb
    begin
        den_wide = {1'b0, max_snap_reg};
        shifted  = cmd.div_first ? rem_reg : {rem_reg[SUM_BITS-1:0], 1'b0};
        ge       = (shifted >= den_wide);
        rem_next = ge ? (shifted - den_wide) : shifted;
        quo_next = {quo_reg[SIM_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_acc_reg   <= '0;
            max_acc_reg   <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_acc_reg <= min_acc_next;
            max_acc_reg <= max_acc_next;
            if (cmd.accept)
            begin
                sat_reg <= cmd.load_div ? 1'b0 : sat_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            min_snap_reg <= min_sum;
            max_snap_reg <= max_sum;
            ovf_snap_reg <= sat_next;
            rem_reg      <= {1'b0, min_sum};
            quo_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            empty_reg   <= (max_snap_reg == '0);
            sim_reg     <= (max_snap_reg == '0) ? '0 : quo_reg;
            sum_min_reg <= min_snap_reg;
            sum_max_reg <= max_snap_reg;
            ovf_reg     <= ovf_snap_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.similarity    = sim_reg;
    assign results.sum_of_minima = sum_min_reg;
    assign results.sum_of_maxima = sum_max_reg;
    assign results.empty_flag    = empty_reg;
    assign results.overflow_flag = ovf_reg;

endmodule

`default_nettype wire

// ===== tb/sv/weighted_jaccard_accumulator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_jaccard_accumulator_tb
// Streams element pairs into the accumulator and checks every similarity
// result against a cycle-free prediction of the saturating min/max sums and
// the truncated Q1.16 ratio. Directed pairs cover extremes, null handling
// and empty vectors; random vectors follow under several sender and
// receiver idling mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module weighted_jaccard_accumulator_tb;

    import wja_pkg::*;

    localparam int VALUE_W    = VALUE_BITS_DEF;
    localparam int SUM_W      = SUM_BITS_DEF;
    localparam int FRAC_W     = FRACTION_BITS_DEF;
    localparam int SIM_W      = FRAC_W + 1;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 175;
    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value_a;
        logic               null_a;
        logic [VALUE_W-1:0] value_b;
        logic               null_b;
        logic               last_element;
    } pair_t;

    typedef struct packed {
        logic [SIM_W-1:0] similarity;
        logic [SUM_W-1:0] sum_of_minima;
        logic [SUM_W-1:0] sum_of_maxima;
        logic             empty_flag;
        logic             overflow_flag;
    } similarity_t;

    logic clk;
    logic rst_n;

    wja_pair_if   #(.VALUE_W(VALUE_W))             pairs_if ();
    wja_result_if #(.SUM_W(SUM_W), .SIM_W(SIM_W)) results_if ();

    weighted_jaccard_accumulator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pairs   (pairs_if),
        .results (results_if)
    );

    pair_t       pending_pairs[$];
    similarity_t expected_similarities[$];

    logic [SUM_W-1:0] min_total;
    logic [SUM_W-1:0] max_total;
    logic             saturated;

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    bit hold_off        = 1'b0;
    bit pressure_go     = 1'b0;
    int mismatch_count  = 0;
    int stall_cycles    = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] total,
                                                     logic [VALUE_W-1:0] value);
        logic [SUM_W:0] wide;
        wide = {1'b0, total} + (SUM_W + 1)'(value);
        if (wide[SUM_W]) begin
            saturated = 1'b1;
            return '1;
        end
        return wide[SUM_W-1:0];
    endfunction

    // running sums per vector, one result on the last pair
    function void accumulate_pair(pair_t p);
        logic [VALUE_W-1:0]      lo;
        logic [VALUE_W-1:0]      hi;
        logic [SUM_W+FRAC_W-1:0] ratio;
        similarity_t             want;
        if (!(p.null_a || p.null_b)) begin
            lo = (p.value_a < p.value_b) ? p.value_a : p.value_b;
            hi = (p.value_a < p.value_b) ? p.value_b : p.value_a;
            min_total = add_clamped(min_total, lo);
            max_total = add_clamped(max_total, hi);
        end
        if (p.last_element) begin
            if (max_total == '0) begin
                want.similarity = '0;
                want.empty_flag = 1'b1;
            end
            else begin
                ratio = {min_total, {FRAC_W{1'b0}}} / max_total;
                want.similarity = ratio[SIM_W-1:0];
                want.empty_flag = 1'b0;
            end
            want.sum_of_minima = min_total;
            want.sum_of_maxima = max_total;
            want.overflow_flag = saturated;
            expected_similarities.push_back(want);
            min_total = '0;
            max_total = '0;
            saturated = 1'b0;
        end
    endfunction

    initial begin
        min_total = '0;
        max_total = '0;
        saturated = 1'b0;
    end

    // driver
    always @(posedge clk or negedge rst_n) begin : drive_pairs
        pair_t next_pair;
        if (!rst_n) begin
            pairs_if.valid        <= 1'b0;
            pairs_if.value_a      <= '0;
            pairs_if.null_a       <= 1'b0;
            pairs_if.value_b      <= '0;
            pairs_if.null_b       <= 1'b0;
            pairs_if.last_element <= 1'b0;
        end
        else begin
            if (pairs_if.valid && pairs_if.ready)
                accumulate_pair('{pairs_if.value_a, pairs_if.null_a, pairs_if.value_b,
                                  pairs_if.null_b, pairs_if.last_element});
            if (!pairs_if.valid || pairs_if.ready) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_pair = pending_pairs.pop_front();
                    pairs_if.valid        <= 1'b1;
                    pairs_if.value_a      <= next_pair.value_a;
                    pairs_if.null_a       <= next_pair.null_a;
                    pairs_if.value_b      <= next_pair.value_b;
                    pairs_if.null_b       <= next_pair.null_b;
                    pairs_if.last_element <= next_pair.last_element;
                end
                else begin
                    pairs_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n) begin : check_results
        similarity_t got;
        similarity_t want;
        if (!rst_n) begin
            results_if.ready <= 1'b0;
        end
        else begin
            results_if.ready <= !hold_off && ($urandom_range(0, 99) >= sink_stall_pct);
            if (results_if.valid && results_if.ready) begin
                got = '{results_if.similarity, results_if.sum_of_minima,
                        results_if.sum_of_maxima, results_if.empty_flag,
                        results_if.overflow_flag};
                if (expected_similarities.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: sim %0d min %0h max %0h empty %0b ovf %0b",
                                 got.similarity, got.sum_of_minima, got.sum_of_maxima,
                                 got.empty_flag, got.overflow_flag);
                end
                else begin
                    want = expected_similarities.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: sim exp %0d got %0d, empty exp %0b got %0b",
                                     want.similarity, got.similarity,
                                     want.empty_flag, got.empty_flag);
                            $display("  min exp %0h got %0h, max exp %0h got %0h",
                                     want.sum_of_minima, got.sum_of_minima,
                                     want.sum_of_maxima, got.sum_of_maxima);
                            $display("  overflow exp %0b got %0b",
                                     want.overflow_flag, got.overflow_flag);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (pairs_if.valid && pairs_if.ready)
                   || (results_if.valid && results_if.ready)
                   || (pending_pairs.size() == 0 && expected_similarities.size() == 0
                       && !pairs_if.valid)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("weighted_jaccard_accumulator_tb: done, errors");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // long receiver hold-off so the block backs up
    initial begin
        wait (pressure_go);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    task automatic push_pair(logic [VALUE_W-1:0] a, logic na,
                             logic [VALUE_W-1:0] b, logic nb, logic last);
        pending_pairs.push_back('{a, na, b, nb, last});
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2, 3:    return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_vectors(int count);
        int length;
        int queued;
        queued = 0;
        while (queued < count) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
            for (int i = 0; i < length; i++)
                push_pair(pick_value(), $urandom_range(0, 9) == 0,
                          pick_value(), $urandom_range(0, 9) == 0, i == length - 1);
            queued += length;
        end
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || expected_similarities.size() != 0
               || pairs_if.valid)
            @(negedge clk);
    endtask

    initial begin
        wait (rst_n === 1'b1);
        @(negedge clk);

        // zero vector, null last, mixed extremes, equal values
        push_pair(0, 0, 0, 0, 1);
        push_pair(32'h1234, 1, 7, 0, 1);
        push_pair(ALL_ONES, 0, 0, 0, 0);
        push_pair(0, 0, ALL_ONES, 0, 0);
        push_pair(5, 0, 5, 0, 1);
        push_pair(1234, 0, 1234, 0, 1);
        // nulls on either side, both, and on the last pair
        push_pair(9, 1, 3, 0, 0);
        push_pair(9, 0, 3, 1, 0);
        push_pair(9, 1, 3, 1, 0);
        push_pair(2, 0, 6, 0, 0);
        push_pair(1, 1, 1, 1, 1);
        push_pair(0, 0, ALL_ONES, 0, 1);
        push_pair(1, 0, 3, 0, 1);
        push_pair(ALL_ONES, 0, ALL_ONES, 0, 1);
        push_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0);
        push_pair(32'h5555_5555, 0, 32'hAAAA_AAAA, 0, 1);
        push_pair(0, 0, 0, 0, 0);
        push_pair(0, 1, 0, 1, 1);
        drain();

        pressure_go = 1'b1;
        queue_random_vectors(PHASE_ITEMS);
        drain();

        sender_idle_pct = 83;
        queue_random_vectors(PHASE_ITEMS);
        drain();

        sender_idle_pct = 0;
        sink_stall_pct  = 83;
        queue_random_vectors(PHASE_ITEMS);
        drain();

        sender_idle_pct = 30;
        sink_stall_pct  = 30;
        queue_random_vectors(PHASE_ITEMS);
        drain();

        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && expected_similarities.size() == 0)
            $display("weighted_jaccard_accumulator_tb: done, clean");
        else
            $display("weighted_jaccard_accumulator_tb: done, errors");
        $finish;
    end

endmodule
